>>> sv/frx_pkg.sv
// Shared types and constants of the framed packet receiver.
// Used by frx_cfg, frx_front, frx_back and framed_packet_receiver; no dependencies.
package frx_pkg;

  localparam int unsigned LenBits     = 20;
  localparam int unsigned LenWordBits = 32;
  localparam int unsigned CfgAddrBits = 4;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [7:0]  StartByte    = 8'h7E;
  localparam logic [7:0]  ZeroByte     = 8'h00;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [15:0] CrcTop       = 16'h8000;
  localparam logic [7:0]  RetryDefault = 8'd14;
  localparam logic [LenBits-1:0] MaxLenDefault = {LenBits{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [1:0] RegExpResp  = 2'd0;
  localparam logic [1:0] RegMaxLen   = 2'd1;
  localparam logic [1:0] RegExactLen = 2'd2;
  localparam logic [1:0] RegRetries  = 2'd3;

  typedef enum logic [2:0] {
    StBusy    = 3'd0,
    StOk      = 3'd1,
    StTimeout = 3'd2,
    StType    = 3'd3,
    StLength  = 3'd4,
    StCmd     = 3'd5,
    StCrc     = 3'd6
  } status_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } frx_in_t;

  typedef struct packed {
    logic               payload_valid;
    logic [7:0]         payload_byte;
    logic               frame_done;
    status_e            frame_status;
    logic [LenBits-1:0] frame_length;
  } frx_out_t;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    logic       is_tick;
    logic       is_start;
    logic [7:0] data;
  } frx_word_t;

  typedef struct packed {
    logic [7:0]         expected_response;
    logic [LenBits-1:0] max_length;
    logic               exact_length;
    logic [7:0]         max_retries;
  } frx_cfg_t;

endpackage

>>> sv/frx_cfg.sv
// Configuration registers of the framed packet receiver behind an APB-style port.
// Depends on frx_pkg.
module frx_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [frx_pkg::CfgAddrBits-1:0]   paddr,
  input  logic [frx_pkg::CfgDataBits-1:0]   pwdata,
  output logic [frx_pkg::CfgDataBits-1:0]   prdata,
  output logic                              pready,
  output frx_pkg::frx_cfg_t                 cfg_o
);
  import frx_pkg::*;

  frx_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CfgAddrBits-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_response <= 8'd0;
      cfg_q.max_length        <= MaxLenDefault;
      cfg_q.exact_length      <= 1'b0;
      cfg_q.max_retries       <= RetryDefault;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegExpResp:  cfg_q.expected_response <= pwdata[7:0];
        RegMaxLen:   cfg_q.max_length        <= pwdata[LenBits-1:0];
        RegExactLen: cfg_q.exact_length      <= pwdata[0];
        RegRetries:  cfg_q.max_retries       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegExpResp:  prdata[7:0]         = cfg_q.expected_response;
      RegMaxLen:   prdata[LenBits-1:0] = cfg_q.max_length;
      RegExactLen: prdata[0]           = cfg_q.exact_length;
      RegRetries:  prdata[7:0]         = cfg_q.max_retries;
      default:     prdata = '0;
    endcase
  end

endmodule

>>> sv/frx_front.sv
// Front part: accepts link words, classifies them and holds them in a two-entry queue.
// Depends on frx_pkg.
module frx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  frx_pkg::frx_in_t    item_i,
  output logic                word_valid_o,
  input  logic                word_ready_i,
  output frx_pkg::frx_word_t  word_o
);
  import frx_pkg::*;

  frx_word_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;
  frx_word_t  cls;

  assign full         = (cnt_q == 2'd2);
  assign word_valid_o = (cnt_q != 2'd0);
  assign word_o       = mem_q[rd_ptr_q];
  assign wr_en        = push & ~full;
  assign rd_en        = word_valid_o & word_ready_i;

  always_comb begin
    cls.is_tick  = item_i.cmd;
    cls.is_start = ~item_i.cmd && (item_i.rx_byte == StartByte);
    cls.data     = item_i.rx_byte;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // The queue never holds more than two words.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("front queue count out of range");

endmodule

>>> sv/frx_back.sv
// Back part: frame parser state machine with checksum and a one-word result register.
// Depends on frx_pkg.
module frx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  frx_pkg::frx_cfg_t   cfg_i,
  input  logic                word_valid_i,
  output logic                word_ready_o,
  input  frx_pkg::frx_word_t  word_i,
  output logic                empty,
  input  logic                pop,
  output frx_pkg::frx_out_t   result_o
);
  import frx_pkg::*;

  typedef enum logic [1:0] {
    PhHunt,
    PhHeader,
    PhPayload,
    PhTrailer
  } phase_e;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    if ((c & CrcTop) != 16'h0000) begin
      return {c[14:0], 1'b0} ^ CrcPoly;
    end
    return {c[14:0], 1'b0};
  endfunction

  phase_e                 phase_q, phase_d;
  logic [2:0]             idx_q, idx_d;
  logic [7:0]             retry_q, retry_d;
  logic [LenWordBits-1:0] len_q, len_d;
  logic [LenBits-1:0]     left_q, left_d;
  logic [15:0]            crc_q, crc_d;
  logic [15:0]            rcrc_q, rcrc_d;
  logic                   tok_q, tok_d;
  logic                   tbad_q, tbad_d;
  logic                   out_valid_q, out_valid_d;
  frx_out_t               out_q, out_d;
  frx_out_t               res;
  logic                   take, fin;
  status_e                fin_st;
  logic [7:0]             b;
  logic [LenWordBits-1:0] max_len_w;
  logic [LenBits-1:0]     left_dec;

  assign word_ready_o = ~out_valid_q | pop;
  assign take         = word_valid_i & word_ready_o;
  assign empty        = ~out_valid_q;
  assign result_o     = out_q;
  assign b            = word_i.data;
  assign max_len_w    = {{(LenWordBits-LenBits){1'b0}}, cfg_i.max_length};
  assign left_dec     = left_q - {{(LenBits-1){1'b0}}, 1'b1};

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    retry_d = retry_q;
    len_d   = len_q;
    left_d  = left_q;
    crc_d   = crc_q;
    rcrc_d  = rcrc_q;
    tok_d   = tok_q;
    tbad_d  = tbad_q;
    fin     = 1'b0;
    fin_st  = StBusy;
    res     = '0;
    res.frame_status = StBusy;

    if (take) begin
      if (phase_q == PhHunt) begin
        if (word_i.is_tick) begin
          if (retry_q >= cfg_i.max_retries) begin
            retry_d = 8'd0;
            fin     = 1'b1;
            fin_st  = StTimeout;
          end else begin
            retry_d = retry_q + 8'd1;
          end
        end else if (word_i.is_start) begin
          retry_d = 8'd0;
          phase_d = PhHeader;
          idx_d   = 3'd1;
          len_d   = '0;
          left_d  = '0;
          crc_d   = 16'h0000;
          rcrc_d  = 16'h0000;
          tok_d   = 1'b1;
          tbad_d  = 1'b0;
        end else begin
          retry_d = 8'd0;
        end
      end else if (word_i.is_tick) begin
        // Any timeout once a frame has started aborts it.
        fin    = 1'b1;
        fin_st = StTimeout;
      end else begin
        unique case (phase_q)
          PhHeader: begin
            crc_d = crc_byte(crc_q, b);
            idx_d = idx_q + 3'd1;
            case (idx_q)
              3'd1: tbad_d = (b != ZeroByte);
              3'd2: len_d[7:0]   = b;
              3'd3: len_d[15:8]  = b;
              3'd4: len_d[23:16] = b;
              3'd5: len_d[31:24] = b;
              default: begin
                if (tbad_q) begin
                  fin = 1'b1; fin_st = StType;
                end else if (len_q > max_len_w) begin
                  fin = 1'b1; fin_st = StLength;
                end else if (b != cfg_i.expected_response) begin
                  fin = 1'b1; fin_st = StCmd;
                end else begin
                  left_d  = len_q[LenBits-1:0];
                  idx_d   = 3'd0;
                  phase_d = (len_q[LenBits-1:0] != '0) ? PhPayload : PhTrailer;
                end
              end
            endcase
          end
          PhPayload: begin
            crc_d             = crc_byte(crc_q, b);
            res.payload_valid = 1'b1;
            res.payload_byte  = b;
            left_d            = left_dec;
            if (left_dec == '0) begin
              idx_d   = 3'd0;
              phase_d = PhTrailer;
            end
          end
          PhTrailer: begin
            idx_d = idx_q + 3'd1;
            case (idx_q)
              3'd0: rcrc_d = {b, 8'h00};
              3'd1: rcrc_d = {rcrc_q[15:8], b};
              3'd2: tok_d  = tok_q & (b == ZeroByte);
              default: begin
                if ((rcrc_q != crc_q) || !tok_q || (b != ZeroByte)) begin
                  fin = 1'b1; fin_st = StCrc;
                end else if (cfg_i.exact_length && (len_q != max_len_w)) begin
                  fin = 1'b1; fin_st = StLength;
                end else begin
                  fin = 1'b1; fin_st = StOk;
                end
              end
            endcase
          end
          default: ;
        endcase
      end

      if (fin) begin
        res.frame_done   = 1'b1;
        res.frame_status = fin_st;
        res.frame_length = (fin_st == StOk) ? len_q[LenBits-1:0] : '0;
        phase_d = PhHunt;
        idx_d   = 3'd0;
        len_d   = '0;
        left_d  = '0;
        crc_d   = 16'h0000;
        rcrc_d  = 16'h0000;
        tok_d   = 1'b1;
        tbad_d  = 1'b0;
      end
    end

    out_d       = take ? res : out_q;
    out_valid_d = take | (out_valid_q & ~pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      idx_q       <= 3'd0;
      retry_q     <= 8'd0;
      len_q       <= '0;
      left_q      <= '0;
      crc_q       <= 16'h0000;
      rcrc_q      <= 16'h0000;
      tok_q       <= 1'b1;
      tbad_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      retry_q     <= retry_d;
      len_q       <= len_d;
      left_q      <= left_d;
      crc_q       <= crc_d;
      rcrc_q      <= rcrc_d;
      tok_q       <= tok_d;
      tbad_q      <= tbad_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // A payload word and a frame end never share one result.
  a_done_xor_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> !(out_q.payload_valid && out_q.frame_done))
    else $error("payload and frame end in the same result");

  // A finished frame always carries a final status, and a length only when it is good.
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && out_q.frame_done) |->
      (out_q.frame_status != StBusy) &&
      (out_q.frame_status == StOk || out_q.frame_length == '0))
    else $error("bad status on finished frame");

  // In the payload phase there is always at least one byte left to stream.
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (phase_q == PhPayload) |-> (left_q != '0))
    else $error("payload phase with nothing left");

  // Hunting always restarts from a clean checksum.
  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (phase_q == PhHunt) |-> (crc_q == 16'h0000 && len_q == '0))
    else $error("frame state not cleared while hunting");

endmodule

>>> sv/framed_packet_receiver.sv
// Top level of the framed packet receiver: link word queue, frame parser, registers.
// Depends on frx_pkg, frx_cfg, frx_front and frx_back.
//
// Usage:
//   Link words enter on push/full/item_i: each word is a received byte (cmd 0)
//   or a receive timeout tick (cmd 1). Every accepted word yields exactly one
//   result word on empty/pop/result_o, in order: a payload byte, a frame end
//   with its status and length, or an idle word otherwise.
//   A frame is start byte 0x7E, six header bytes (type, little-endian length,
//   command), the payload and a four-byte trailer with a big-endian checksum.
//   A word accepted on push is stored in the queue and then taken into the result
//   register, which drives the result ports. While results are popped, throughput
//   is one word per cycle; the parser state machine handles one word per cycle and
//   a two-entry queue sits in front of it.
//   When the receiver stops popping, the result register holds, the queue
//   fills, and full rises after two more words; nothing is lost.
//   Reset clears the queue, the result register and the frame state, and
//   loads the register defaults (maximum length all ones, 14 retries).
//   Write registers (APB-style port) only with no word in flight; nothing checks it.
module framed_packet_receiver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  frx_pkg::frx_in_t                  item_i,
  output logic                              empty,
  input  logic                              pop,
  output frx_pkg::frx_out_t                 result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [frx_pkg::CfgAddrBits-1:0]   paddr,
  input  logic [frx_pkg::CfgDataBits-1:0]   pwdata,
  output logic [frx_pkg::CfgDataBits-1:0]   prdata,
  output logic                              pready
);
  import frx_pkg::*;

  frx_cfg_t  cfg;
  frx_word_t word;
  logic      word_valid;
  logic      word_ready;

  frx_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  frx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (item_i),
    .word_valid_o (word_valid),
    .word_ready_i (word_ready),
    .word_o       (word)
  );

  frx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .word_valid_i (word_valid),
    .word_ready_o (word_ready),
    .word_i       (word),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

endmodule
